// ----- design/frlw_pkg.sv -----
// ---------------------------------------------------------------------------
// frlw_pkg
// Shared types and constants for the queued resource lock manager.
// ---------------------------------------------------------------------------
package frlw_pkg;

   localparam int NUM_RESOURCES = 8;
   localparam int NUM_CLIENTS   = 16;
   localparam int QUEUE_DEPTH   = 16;
   localparam int RES_W  = 3;
   localparam int CLI_W  = 4;
   localparam int POS_W  = 4;
   localparam int CNT_W  = 5;
   localparam int ADDR_W = RES_W + POS_W;

   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_REL_ALL = 2'd2;
   localparam logic [1:0] OP_YIELD   = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_QUEUED  = 2'd1;
   localparam logic [1:0] ST_NOT_OWN = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [CLI_W-1:0] client;
      logic [RES_W-1:0] resource;
      logic             yield_value;
      logic [15:0]      tag;
   } req_type_type;

   typedef struct packed {
      logic             event_res;
      logic [CLI_W-1:0] grant_client;
      logic [RES_W-1:0] grant_resource;
      logic [15:0]      grant_tag;
      logic [1:0]       status;
      logic             resource_busy;
      logic             last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RES_NEXT,
      S_EMIT,
      S_BUSY_RD,
      S_BUSY,
      S_FINAL
   } state_type;

endpackage

// ----- design/fifo_resource_lock_with_yield.sv -----
// ---------------------------------------------------------------------------
// fifo_resource_lock_with_yield
// Lock manager: eight resources with an owner and a FIFO of waiters each.
// ---------------------------------------------------------------------------
// One request beat at a time. A small sequencer walks the wait queues entry
// by entry through a queue memory with one read and one write port. A
// request runs the busy test twice, and a single release scans, shifts and
// tests once. Release-all and a yield change visit every resource, and
// release-all purges the client from every queue. Grant beats wait while
// the receiver holds them off. Grant beats go out in ascending resource
// order, then one final status beat with last set. req_ready is low from
// acceptance until the status beat has been taken.
module fifo_resource_lock_with_yield
   import frlw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   // queue memory
   logic [CLI_W-1:0] queue_mem [NUM_RESOURCES*QUEUE_DEPTH];
   logic [CLI_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CLI_W-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= queue_mem[mem_raddr];
   end

   // state
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [NUM_RESOURCES-1:0] own_v_ff, own_v_in;
   logic [CLI_W-1:0] own_id_ff [NUM_RESOURCES];
   logic [CLI_W-1:0] own_id_in [NUM_RESOURCES];
   logic [NUM_CLIENTS-1:0] yld_ff, yld_in;
   logic [CNT_W-1:0] cnt_ff [NUM_RESOURCES];
   logic [CNT_W-1:0] cnt_in [NUM_RESOURCES];
   req_type_type req_ff, req_in;
   logic [RES_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [1:0] st_ff, st_in;
   logic busy_ff, busy_in;
   // phase of multi-step ops: 0 first pass, 1 second pass / enqueue pending
   logic ph_ff, ph_in;
   logic rsp_v_ff, rsp_v_in;
   rsp_type rsp_ff, rsp_in;

   logic [CNT_W-1:0] cur_cnt;
   logic [CLI_W-1:0] cli;
   assign cli = req_ff.client;
   assign cur_cnt = cnt_ff[k_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         own_v_ff <= '0;
         yld_ff   <= '0;
         rsp_v_ff <= 1'b0;
         k_ff     <= '0;
         for (int n = 0; n < NUM_RESOURCES; n++) begin
            cnt_ff[n]    <= '0;
            own_id_ff[n] <= '0;
         end
      end else begin
         state_ff <= state_in;
         own_v_ff <= own_v_in;
         yld_ff   <= yld_in;
         rsp_v_ff <= rsp_v_in;
         k_ff     <= k_in;
         for (int n = 0; n < NUM_RESOURCES; n++) begin
            cnt_ff[n]    <= cnt_in[n];
            own_id_ff[n] <= own_id_in[n];
         end
      end
      ret_ff  <= ret_in;
      req_ff  <= req_in;
      i_ff    <= i_in;
      st_ff   <= st_in;
      busy_ff <= busy_in;
      ph_ff   <= ph_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // Scan modes (in ret_ff of S_SCAN meaning): handled by op/phase below.
   // Entry match test used by scan: for handoff/busy the first non-yielder;
   // for removal/claim an entry equal to the client.
   logic want_handoff;   // scanning current resource for a hand-off
   always_comb begin
      want_handoff = 1'b0;
      case (req_ff.req_type)
         OP_RELEASE: want_handoff = 1'b1;
         OP_REL_ALL: want_handoff = ph_ff;
         OP_YIELD:   want_handoff = req_ff.yield_value;
         default:    want_handoff = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      req_in   = req_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      st_in    = st_ff;
      busy_in  = busy_ff;
      ph_in    = ph_ff;
      own_v_in = own_v_ff;
      own_id_in = own_id_ff;
      yld_in   = yld_ff;
      cnt_in   = cnt_ff;
      rsp_v_in = rsp_v_ff;
      rsp_in   = rsp_ff;
      mem_we   = 1'b0;
      mem_waddr = {k_ff, i_ff[POS_W-1:0]};
      mem_wdata = cli;
      mem_raddr = {k_ff, i_ff[POS_W-1:0]};
      if (rsp_v_ff && rsp_ready) rsp_v_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_v_ff) begin
               req_in = req_data;
               st_in = ST_DONE;
               k_in = '0;
               i_in = '0;
               ph_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_BUSY_RD;
            i_in = '0;
            k_in = req_ff.resource;
            case (req_ff.req_type)
               OP_REQUEST: begin
                  // busy test first, then decide
                  ret_in = S_DISPATCH;
                  if (!ph_ff) begin
                     ph_in = 1'b1;
                     state_in = S_BUSY_RD;
                  end else begin
                     if (busy_ff || yld_ff[cli]) begin
                        if (cnt_ff[k_ff] >= CNT_W'(QUEUE_DEPTH)) begin
                           st_in = ST_FULL;
                        end else begin
                           mem_we = 1'b1;
                           mem_waddr = {k_ff, cnt_ff[k_ff][POS_W-1:0]};
                           cnt_in[k_ff] = cnt_ff[k_ff] + 1'b1;
                           st_in = ST_QUEUED;
                        end
                        ret_in = S_FINAL;
                        state_in = S_BUSY_RD;
                     end else begin
                        own_v_in[k_ff] = 1'b1;
                        own_id_in[k_ff] = cli;
                        rsp_in = '{1'b1, cli, k_ff, req_ff.tag, ST_DONE, 1'b0, 1'b0};
                        rsp_v_in = 1'b1;
                        ret_in = S_FINAL;
                        state_in = S_EMIT;
                     end
                  end
               end
               OP_RELEASE: begin
                  if (own_v_ff[k_in] && own_id_ff[k_in] == cli) begin
                     own_v_in[k_in] = 1'b0;
                     state_in = S_SCAN_RD;
                  end else begin
                     st_in = ST_NOT_OWN;
                     ret_in = S_FINAL;
                  end
               end
               OP_REL_ALL: begin
                  k_in = '0;
                  state_in = S_SCAN_RD;
               end
               default: begin
                  k_in = '0;
                  if (yld_ff[cli] == req_ff.yield_value) begin
                     ret_in = S_FINAL;
                     k_in = req_ff.resource;
                  end else begin
                     yld_in[cli] = req_ff.yield_value;
                     state_in = S_RES_NEXT;
                     ph_in = 1'b1; // first visit to resource 0
                  end
               end
            endcase
            if (state_in == S_BUSY_RD && req_ff.req_type != OP_REQUEST)
               ret_in = S_FINAL;
         end
         // per-resource entry for walking ops (release all, yield)
         S_RES_NEXT: begin
            i_in = '0;
            state_in = S_RES_NEXT;
            if (req_ff.req_type == OP_YIELD) begin
               if (!ph_ff) begin
                  // advance
                  if (k_ff == RES_W'(NUM_RESOURCES-1)) begin
                     k_in = req_ff.resource;
                     ret_in = S_FINAL;
                     state_in = S_BUSY_RD;
                  end else begin
                     k_in = k_ff + 1'b1;
                     ph_in = 1'b1;
                  end
               end else begin
                  ph_in = 1'b0;
                  if (req_ff.yield_value) begin
                     if (own_v_ff[k_ff] && own_id_ff[k_ff] == cli) begin
                        own_v_in[k_ff] = 1'b0;
                        state_in = S_SCAN_RD;
                     end
                  end else if (!own_v_ff[k_ff]) begin
                     state_in = S_SCAN_RD;
                  end
               end
            end else begin
               // release all: ph 0 = purge pass, ph 1 = owner pass
               if (k_ff == RES_W'(NUM_RESOURCES-1)) begin
                  k_in = '0;
                  if (!ph_ff) begin
                     ph_in = 1'b1;
                     state_in = S_SCAN_RD;
                     if (!(own_v_ff[0] && own_id_ff[0] == cli)) state_in = S_RES_NEXT;
                     else own_v_in[0] = 1'b0;
                     if (state_in == S_RES_NEXT) k_in = '0;
                     ret_in = S_IDLE; // marker: k=0 checked
                  end else begin
                     k_in = req_ff.resource;
                     ret_in = S_FINAL;
                     state_in = S_BUSY_RD;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
                  if (!ph_ff) state_in = S_SCAN_RD;
                  else if (own_v_ff[k_in] && own_id_ff[k_in] == cli) begin
                     own_v_in[k_in] = 1'b0;
                     state_in = S_SCAN_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            mem_raddr = {k_ff, i_ff[POS_W-1:0]};
            if (i_ff >= cur_cnt) begin
               // no matching entry in this queue
               if (req_ff.req_type == OP_YIELD && req_ff.yield_value) begin
                  if (cur_cnt >= CNT_W'(QUEUE_DEPTH)) st_in = ST_FULL;
                  else begin
                     mem_we = 1'b1;
                     mem_waddr = {k_ff, cur_cnt[POS_W-1:0]};
                     cnt_in[k_ff] = cur_cnt + 1'b1;
                  end
               end
               state_in = (req_ff.req_type == OP_RELEASE) ? S_BUSY_RD : S_RES_NEXT;
               if (req_ff.req_type == OP_RELEASE) begin
                  ret_in = S_FINAL;
                  k_in = req_ff.resource;
               end
            end else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (want_handoff ? !yld_ff[rd_data_ff] : (rd_data_ff == cli)) begin
               // remove entry i, then maybe grant
               state_in = S_SHIFT_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            // on first entry remember the found client in rsp payload
            if (i_ff + 1'b1 >= cur_cnt) begin
               cnt_in[k_ff] = cur_cnt - 1'b1;
               if (want_handoff || req_ff.req_type == OP_YIELD) begin
                  own_v_in[k_ff] = 1'b1;
                  own_id_in[k_ff] = rsp_ff.grant_client;
                  rsp_in = '{1'b1, rsp_ff.grant_client, k_ff, 16'd0, ST_DONE,
                             1'b0, 1'b0};
                  rsp_v_in = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  // purge: the shift moved the index, scan this queue again
                  i_in = '0;
                  state_in = S_SCAN_RD;
               end
            end else begin
               mem_raddr = {k_ff, POS_W'(i_ff + 1'b1)};
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            mem_we = 1'b1;
            mem_waddr = {k_ff, i_ff[POS_W-1:0]};
            mem_wdata = rd_data_ff;
            i_in = i_ff + 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_EMIT: begin
            if (!rsp_v_ff || rsp_ready) begin
               rsp_v_in = 1'b0;
               if (req_ff.req_type == OP_REQUEST) begin
                  ret_in = S_FINAL;
                  state_in = S_BUSY_RD;
                  i_in = '0;
               end else if (req_ff.req_type == OP_RELEASE) begin
                  ret_in = S_FINAL;
                  k_in = req_ff.resource;
                  i_in = '0;
                  state_in = S_BUSY_RD;
               end else if (req_ff.req_type == OP_YIELD && req_ff.yield_value) begin
                  i_in = cur_cnt;
                  state_in = S_SCAN_RD; // falls into enqueue at tail
               end else begin
                  state_in = S_RES_NEXT;
               end
            end
         end
         S_BUSY_RD: begin
            if (!own_v_ff[k_ff] && i_ff < cur_cnt) state_in = S_BUSY;
            else begin
               busy_in = own_v_ff[k_ff];
               state_in = ret_ff;
            end
         end
         S_BUSY: begin
            if (!yld_ff[rd_data_ff]) begin
               busy_in = 1'b1;
               state_in = ret_ff;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_BUSY_RD;
               mem_raddr = {k_ff, POS_W'(i_ff + 1'b1)};
            end
         end
         S_FINAL: begin
            if (!rsp_v_ff || rsp_ready) begin
               rsp_in = '{1'b0, '0, '0, 16'd0, st_ff, busy_ff, 1'b1};
               rsp_v_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // grant payload staging: the found client rides in rsp_ff.grant_client
      if (state_ff == S_SCAN && state_in == S_SHIFT_RD && !rsp_v_ff)
         rsp_in.grant_client = rd_data_ff;
   end

   // assertions
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_data.last) else $error("ready while busy");
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !rsp_data.event_res) else $error("bad last");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[k_ff] <= CNT_W'(QUEUE_DEPTH)) else $error("queue overflow");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the queued resource lock manager.
// ---------------------------------------------------------------------------
// A behavioural lock table (owners, yield flags, wait FIFOs) predicts every
// grant and status beat of each accepted request beat. The checker compares
// each result beat, field by field, against the oldest prediction. Directed
// tests cover grants, queueing, releases, release-all, yield in both
// directions and full queues. Random phases then run with the sender and
// receiver idling at varied rates, with a long receiver hold-off thrown in.
// ---------------------------------------------------------------------------
module tb_top
   import frlw_pkg::*;
;

   localparam int WDOG_LIMIT = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;

   // lock table as the bench sees it
   logic       own_vld [NUM_RESOURCES];
   logic [3:0] own_id  [NUM_RESOURCES];
   logic       yld     [NUM_CLIENTS];
   logic [3:0] waitq   [NUM_RESOURCES][$];
   rsp_type    beats_due[$];

   int errors;
   int beats_seen;
   int idle_pct;
   int stall_pct;
   int hold_cycles;
   int quiet_cycles;
   int items_sent;
   int grants_seen;

   fifo_resource_lock_with_yield i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // lock table model
   // ------------------------------------------------------------------
   function automatic logic res_busy(int r);
      if (own_vld[r]) return 1'b1;
      foreach (waitq[r][i])
         if (!yld[waitq[r][i]]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void give(int r, logic [3:0] c, logic [15:0] tg);
      rsp_type b;
      own_vld[r] = 1'b1;
      own_id[r]  = c;
      b = '0;
      b.event_res      = 1'b1;
      b.grant_client   = c;
      b.grant_resource = r[RES_W-1:0];
      b.grant_tag      = tg;
      beats_due.push_back(b);
   endfunction

   function automatic void hand_over(int r);
      own_vld[r] = 1'b0;
      foreach (waitq[r][i]) begin
         if (!yld[waitq[r][i]]) begin
            logic [3:0] c;
            c = waitq[r][i];
            waitq[r].delete(i);
            give(r, c, 16'h0);
            return;
         end
      end
   endfunction

   function automatic logic join_queue(int r, logic [3:0] c);
      if (waitq[r].size() >= QUEUE_DEPTH) return 1'b0;
      waitq[r].push_back(c);
      return 1'b1;
   endfunction

   function automatic logic holds(int r, logic [3:0] c);
      return own_vld[r] && own_id[r] == c;
   endfunction

   function automatic void predict_locks(req_type_type q);
      rsp_type    fin;
      logic [1:0] st;
      int         r;
      r  = int'(q.resource);
      st = ST_DONE;
      case (q.req_type)
         OP_REQUEST: begin
            if (res_busy(r) || yld[q.client])
               st = join_queue(r, q.client) ? ST_QUEUED : ST_FULL;
            else
               give(r, q.client, q.tag);
         end
         OP_RELEASE: begin
            if (holds(r, q.client)) hand_over(r);
            else st = ST_NOT_OWN;
         end
         OP_REL_ALL: begin
            for (int k = 0; k < NUM_RESOURCES; k++) begin
               int i;
               i = 0;
               while (i < waitq[k].size()) begin
                  if (waitq[k][i] == q.client) waitq[k].delete(i);
                  else i++;
               end
            end
            for (int k = 0; k < NUM_RESOURCES; k++)
               if (holds(k, q.client)) hand_over(k);
         end
         default: begin
            if (yld[q.client] != q.yield_value) begin
               yld[q.client] = q.yield_value;
               for (int k = 0; k < NUM_RESOURCES; k++) begin
                  if (q.yield_value) begin
                     if (holds(k, q.client)) begin
                        hand_over(k);
                        if (!join_queue(k, q.client)) st = ST_FULL;
                     end
                  end else if (!own_vld[k]) begin
                     foreach (waitq[k][i]) begin
                        if (waitq[k][i] == q.client) begin
                           waitq[k].delete(i);
                           give(k, q.client, 16'h0);
                           break;
                        end
                     end
                  end
               end
            end
         end
      endcase
      fin = '0;
      fin.status        = st;
      fin.resource_busy = res_busy(r);
      fin.last          = 1'b1;
      beats_due.push_back(fin);
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic report(string what, int got, int want);
      errors++;
      $display("mismatch at %0t beat %0d: %s got %0h want %0h",
               $realtime, beats_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_type w;
         if (beats_due.size() == 0) begin
            report("unexpected beat, event", rsp_data.event_res, 0);
         end else begin
            w = beats_due.pop_front();
            if (rsp_data.event_res != w.event_res)
               report("event_res", rsp_data.event_res, w.event_res);
            if (rsp_data.grant_client != w.grant_client)
               report("grant_client", rsp_data.grant_client, w.grant_client);
            if (rsp_data.grant_resource != w.grant_resource)
               report("grant_resource", rsp_data.grant_resource, w.grant_resource);
            if (rsp_data.grant_tag != w.grant_tag)
               report("grant_tag", rsp_data.grant_tag, w.grant_tag);
            if (rsp_data.status != w.status)
               report("status", rsp_data.status, w.status);
            if (rsp_data.resource_busy != w.resource_busy)
               report("resource_busy", rsp_data.resource_busy, w.resource_busy);
            if (rsp_data.last != w.last)
               report("last", rsp_data.last, w.last);
            if (w.event_res) grants_seen++;
         end
         beats_seen++;
      end
   end

   // watchdog: cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("watchdog expired, %0d beats outstanding", beats_due.size());
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic send(logic [1:0] op, int c, int r, logic yv, logic [15:0] tg);
      req_type_type q;
      q.req_type    = op;
      q.client      = c[CLI_W-1:0];
      q.resource    = r[RES_W-1:0];
      q.yield_value = yv;
      q.tag         = tg;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_locks(q);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (beats_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic random_item();
      int         pick;
      int         c;
      int         r;
      logic [1:0] op;
      pick = $urandom_range(99);
      c    = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(5);
      r    = $urandom_range(7);
      if (pick < 40) op = OP_REQUEST;
      else if (pick < 70) op = OP_RELEASE;
      else if (pick < 78) op = OP_REL_ALL;
      else op = OP_YIELD;
      // most releases come from the real owner so hand-offs happen
      if (op == OP_RELEASE && own_vld[r] && $urandom_range(3) != 0) c = int'(own_id[r]);
      send(op, c, r, 1'($urandom_range(1)), 16'($urandom_range(16'hffff)));
   endtask

   task automatic test_grant_release();
      send(OP_REQUEST, 0, 0, 1'b0, 16'hffff);
      send(OP_REQUEST, 15, 7, 1'b1, 16'h0000);
      send(OP_REQUEST, 1, 0, 1'b0, 16'h1234);
      send(OP_RELEASE, 2, 0, 1'b0, 16'h0);
      send(OP_RELEASE, 3, 5, 1'b0, 16'h0);
      send(OP_RELEASE, 0, 0, 1'b0, 16'h0);
      send(OP_RELEASE, 1, 0, 1'b0, 16'h0);
   endtask

   task automatic test_release_all();
      for (int k = 0; k < NUM_RESOURCES; k++)
         send(OP_REQUEST, 4, k, 1'b0, 16'(16'ha5a5 + k));
      send(OP_REQUEST, 6, 2, 1'b0, 16'h0);
      send(OP_REQUEST, 4, 3, 1'b0, 16'h0);
      send(OP_REL_ALL, 4, 0, 1'b0, 16'h0);
      send(OP_REL_ALL, 6, 2, 1'b0, 16'h0);
   endtask

   task automatic test_yield();
      send(OP_REQUEST, 7, 1, 1'b0, 16'h0bad);
      send(OP_REQUEST, 8, 1, 1'b0, 16'h0);
      send(OP_YIELD, 7, 1, 1'b0, 16'h0);
      send(OP_YIELD, 7, 1, 1'b1, 16'h0);
      send(OP_REQUEST, 9, 4, 1'b0, 16'h0);
      send(OP_REQUEST, 7, 3, 1'b0, 16'h0);
      send(OP_YIELD, 7, 3, 1'b0, 16'h0);
      send(OP_REL_ALL, 7, 0, 1'b0, 16'h0);
      send(OP_REL_ALL, 8, 0, 1'b0, 16'h0);
      send(OP_REL_ALL, 9, 0, 1'b0, 16'h0);
   endtask

   task automatic test_queue_full();
      // a yielding waiter fills resource 1, so hand-offs find nobody
      send(OP_REQUEST, 2, 1, 1'b0, 16'h5555);
      send(OP_YIELD, 5, 1, 1'b1, 16'h0);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send(OP_REQUEST, 5, 1, 1'b0, 16'h0);
      send(OP_REQUEST, 5, 1, 1'b0, 16'h0);
      send(OP_YIELD, 2, 1, 1'b1, 16'h0);
      send(OP_YIELD, 5, 1, 1'b0, 16'h0);
      send(OP_REL_ALL, 5, 0, 1'b0, 16'h0);
      send(OP_YIELD, 2, 1, 1'b0, 16'h0);
      send(OP_REL_ALL, 2, 0, 1'b0, 16'h0);
   endtask

   task automatic test_random(int n, int idle, int stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (n) random_item();
   endtask

   task automatic test_backpressure();
      // receiver holds off while the sender keeps offering beats
      stall_pct   = 0;
      idle_pct    = 0;
      hold_cycles = 300;
      repeat (8) random_item();
      wait_drained();
   endtask

   initial begin
      errors      = 0;
      beats_seen  = 0;
      grants_seen = 0;
      items_sent  = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      hold_cycles = 0;
      quiet_cycles = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      for (int k = 0; k < NUM_RESOURCES; k++) begin
         own_vld[k] = 1'b0;
         own_id[k]  = '0;
      end
      for (int c = 0; c < NUM_CLIENTS; c++) yld[c] = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_grant_release();
      test_release_all();
      test_yield();
      test_queue_full();
      wait_drained();
      test_random(35, 0, 0);
      test_random(35, 57, 0);
      wait_drained();
      test_random(35, 0, 57);
      test_backpressure();
      test_random(35, 24, 24);
      wait_drained();
      repeat (400) @(negedge clock);

      $display("ran %0d request beats, checked %0d result beats (%0d grants)",
               items_sent, beats_seen, grants_seen);
      $display("covered grants, queueing, releases, yield changes, full queues, stalls");
      if (errors == 0 && beats_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d beats missing", errors, beats_due.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/frlw_pkg.sv
design/fifo_resource_lock_with_yield.sv
bench/tb_top.sv
